@@ hw/rtl/adnp_pkg.sv @@
// ----------------------------------------------------------------------------
// adnp_pkg
// Types and character codes shared by the ASCII decimal number parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adnp_pkg;

   localparam int IntW  = 34;
   localparam int CntOW = 4;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic             parse_ok;
      logic             is_negative;
      logic [IntW-1:0]  int_part;
      logic [IntW-1:0]  frac_value;
      logic [CntOW-1:0] frac_count;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_MINUS,
      CLS_PLUS,
      CLS_TERM,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [3:0] digit;
   } token_type;

endpackage

`default_nettype wire

@@ hw/rtl/adnp_stream_if.sv @@
// ----------------------------------------------------------------------------
// adnp_stream_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface adnp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ascii_decimal_number_parser.sv @@
// Path: a terminator byte passes the token queue, then the result register.
// Throughput: one byte per cycle unless stalled, set by the back end's single
// multiply-by-ten-and-add per cycle; a 2-entry token queue decouples the ends.
// Reset: synchronous; empties the queue, drops any pending result and
// returns the parser to the start of a string.
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Parses a NUL-terminated decimal string into sign, integer and fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ascii_decimal_number_parser #(
   parameter int MAX_DIGITS = 10
) (
   input  wire           clock,
   input  wire           reset,
   adnp_stream_if.sink   req_if,
   adnp_stream_if.source rsp_if
);

   adnp_stream_if #(.payload_type(adnp_pkg::token_type)) tok_front_if ();
   adnp_stream_if #(.payload_type(adnp_pkg::token_type)) tok_back_if ();

   adnp_front u_front (
      .req_if (req_if),
      .tok_if (tok_front_if)
   );

   adnp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .in_if  (tok_front_if),
      .out_if (tok_back_if)
   );

   adnp_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .tok_if (tok_back_if),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

@@ hw/rtl/adnp_front.sv @@
// ----------------------------------------------------------------------------
// adnp_front
// Classifies each incoming byte into a token for the parser back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adnp_front (
   adnp_stream_if.sink   req_if,
   adnp_stream_if.source tok_if
);

   logic [7:0]         code;
   logic [7:0]         offset;
   adnp_pkg::cls_type  cls;

   assign code   = req_if.payload.char_code;
   assign offset = code - adnp_pkg::CHAR_ZERO;

   always_comb begin
      priority if (code == adnp_pkg::CHAR_NUL) begin
         cls = adnp_pkg::CLS_TERM;
      end else if (code == adnp_pkg::CHAR_DOT) begin
         cls = adnp_pkg::CLS_DOT;
      end else if (code == adnp_pkg::CHAR_MINUS) begin
         cls = adnp_pkg::CLS_MINUS;
      end else if (code == adnp_pkg::CHAR_PLUS) begin
         cls = adnp_pkg::CLS_PLUS;
      end else if (code >= adnp_pkg::CHAR_ZERO && code <= adnp_pkg::CHAR_NINE) begin
         cls = adnp_pkg::CLS_DIGIT;
      end else begin
         cls = adnp_pkg::CLS_OTHER;
      end
   end

   assign tok_if.valid         = req_if.valid;
   assign tok_if.payload.cls   = cls;
   assign tok_if.payload.digit = offset[3:0];
   assign req_if.ready         = tok_if.ready;

endmodule

`default_nettype wire

@@ hw/rtl/adnp_queue.sv @@
// ----------------------------------------------------------------------------
// adnp_queue
// Two-entry token queue between the classifier and the parser back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adnp_queue (
   input  wire           clock,
   input  wire           reset,
   adnp_stream_if.sink   in_if,
   adnp_stream_if.source out_if
);

   localparam int Depth = 2;

   adnp_pkg::token_type entry_ff [Depth];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff,  count_in;
   logic                push, pop;

   assign in_if.ready    = (count_ff != 2'(Depth));
   assign out_if.valid   = (count_ff != 2'd0);
   assign out_if.payload = entry_ff[rd_ptr_ff];

   assign push = in_if.valid && in_if.ready;
   assign pop  = out_if.valid && out_if.ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_if.payload;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/adnp_back.sv @@
// ----------------------------------------------------------------------------
// adnp_back
// Parser state machine: accumulates digits and emits one result per string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adnp_back #(
   parameter int MAX_DIGITS = 10
) (
   input  wire           clock,
   input  wire           reset,
   adnp_stream_if.sink   tok_if,
   adnp_stream_if.source rsp_if
);

   localparam int CntW = $clog2(MAX_DIGITS + 1);
   localparam int ExtW = CntW + adnp_pkg::CntOW;
   localparam int IntW = adnp_pkg::IntW;

   typedef enum logic [1:0] {
      PH_START,
      PH_SIGNED,
      PH_BODY,
      PH_FAIL
   } phase_type;

   phase_type           phase_ff,     phase_in;
   logic                neg_ff,       neg_in;
   logic                dot_ff,       dot_in;
   logic [CntW-1:0]     int_cnt_ff,   int_cnt_in;
   logic [CntW-1:0]     frac_cnt_ff,  frac_cnt_in;
   logic [IntW-1:0]     int_acc_ff,   int_acc_in;
   logic [IntW-1:0]     frac_acc_ff,  frac_acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   adnp_pkg::rsp_type   rsp_data_ff,  rsp_data_in;

   adnp_pkg::token_type tok;
   logic                is_term;
   logic                pop;
   logic [IntW-1:0]     digit_ext;
   logic [IntW-1:0]     int_step;
   logic [IntW-1:0]     frac_step;
   logic [ExtW-1:0]     frac_cnt_ext;

   assign tok     = tok_if.payload;
   assign is_term = (tok.cls == adnp_pkg::CLS_TERM);

   assign tok_if.ready   = !is_term || !rsp_valid_ff || rsp_if.ready;
   assign pop            = tok_if.valid && tok_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign digit_ext    = IntW'(tok.digit);
   assign int_step     = (int_acc_ff << 3) + (int_acc_ff << 1) + digit_ext;
   assign frac_step    = (frac_acc_ff << 3) + (frac_acc_ff << 1) + digit_ext;
   assign frac_cnt_ext = ExtW'(frac_cnt_ff);

   always_comb begin
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      dot_in       = dot_ff;
      int_cnt_in   = int_cnt_ff;
      frac_cnt_in  = frac_cnt_ff;
      int_acc_in   = int_acc_ff;
      frac_acc_in  = frac_acc_ff;
      rsp_valid_in = rsp_if.ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (pop) begin
         priority if (is_term) begin
            rsp_valid_in = 1'b1;
            if (phase_ff == PH_BODY) begin
               rsp_data_in.parse_ok    = 1'b1;
               rsp_data_in.is_negative = neg_ff;
               rsp_data_in.int_part    = int_acc_ff;
               rsp_data_in.frac_value  = frac_acc_ff;
               rsp_data_in.frac_count  = frac_cnt_ext[adnp_pkg::CntOW-1:0];
            end else begin
               rsp_data_in = '0;
            end
            phase_in    = PH_START;
            neg_in      = 1'b0;
            dot_in      = 1'b0;
            int_cnt_in  = '0;
            frac_cnt_in = '0;
            int_acc_in  = '0;
            frac_acc_in = '0;
         end else if (phase_ff != PH_FAIL) begin
            unique case (tok.cls)
               adnp_pkg::CLS_MINUS: begin
                  if (phase_ff == PH_START) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGNED;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               adnp_pkg::CLS_PLUS: begin
                  phase_in = (phase_ff == PH_START) ? PH_SIGNED : PH_FAIL;
               end
               adnp_pkg::CLS_DOT: begin
                  if (dot_ff) begin
                     phase_in = PH_FAIL;
                  end else begin
                     dot_in   = 1'b1;
                     phase_in = PH_BODY;
                  end
               end
               adnp_pkg::CLS_DIGIT: begin
                  if (!dot_ff) begin
                     if (int_cnt_ff >= CntW'(MAX_DIGITS)) begin
                        phase_in = PH_FAIL;
                     end else begin
                        phase_in   = PH_BODY;
                        int_acc_in = int_step;
                        int_cnt_in = int_cnt_ff + CntW'(1);
                     end
                  end else begin
                     if (frac_cnt_ff >= CntW'(MAX_DIGITS)) begin
                        phase_in = PH_FAIL;
                     end else begin
                        phase_in    = PH_BODY;
                        frac_acc_in = frac_step;
                        frac_cnt_in = frac_cnt_ff + CntW'(1);
                     end
                  end
               end
               default: begin
                  phase_in = PH_FAIL;
               end
            endcase
         end else begin
            phase_in = PH_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         neg_ff       <= 1'b0;
         dot_ff       <= 1'b0;
         int_cnt_ff   <= '0;
         frac_cnt_ff  <= '0;
         int_acc_ff   <= '0;
         frac_acc_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         dot_ff       <= dot_in;
         int_cnt_ff   <= int_cnt_in;
         frac_cnt_ff  <= frac_cnt_in;
         int_acc_ff   <= int_acc_in;
         frac_acc_ff  <= frac_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire
